### src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GSMF_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("gsmf assertion failed");

// next-cycle implication
`define GSMF_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("gsmf assertion failed");

`endif

### src/gsmf_pkg.sv
// types and constants of the small-move filter
package gsmf_pkg;

  localparam int FRAC_DIGITS = 3;

  localparam logic [29:0] MAG_MAX = '1;
  localparam logic [29:0] MIN_MOVE_RESET = 30'd1000;
  localparam logic [29:0] G_LIMIT = 30'(2 * (10 ** FRAC_DIGITS));

  localparam logic REG_MIN_MOVE = 1'b0;

  localparam logic [1:0] REASON_SMALL = 2'd0;
  localparam logic [1:0] REASON_MOVE  = 2'd1;
  localparam logic [1:0] REASON_OTHER = 2'd2;

  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_LO_X   = 8'h78;
  localparam logic [7:0] CH_LO_Y   = 8'h79;
  localparam logic [7:0] CH_LO_G   = 8'h67;
  localparam logic [7:0] CASE_BIT  = 8'h20;

  typedef enum logic [1:0] {
    LETTER_NONE,
    LETTER_X,
    LETTER_Y,
    LETTER_G
  } letter_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last_in_line;
  } char_word_t;

  typedef struct packed {
    logic       send_line;
    logic [1:0] decision_reason;
  } result_word_t;

  typedef struct packed {
    logic signed [30:0] line_x;
    logic signed [30:0] line_y;
    logic               in_comment;
    logic               line_decided;
    logic [1:0]         decided_reason;
    logic               in_number;
    letter_t            pending_letter;
    logic [29:0]        number_value;
    logic [1:0]         fraction_digits;
    logic               seen_point;
    logic               number_negative;
    logic               at_number_start;
  } line_state_t;

  function automatic logic [9:0] pow10(input logic [1:0] j);
    logic [9:0] p;
    unique case (j)
      2'd0: p = 10'd1;
      2'd1: p = 10'd10;
      2'd2: p = 10'd100;
      2'd3: p = 10'd1000;
      default: p = 10'd1;
    endcase
    return p;
  endfunction

endpackage

### src/gcode_small_move_filter_core.sv
// small-move filter for g-code lines: top level with input, result and register stages
//
// Takes one character word per cycle; the line's decision word leaves on the cycle after
// its last character is parsed. Each character passes through one registered parse stage,
// so the sustained rate is one character per cycle; the input stalls only while a decision
// word waits at the output and the next last character needs the result register. min_move
// sits at byte address 0 of the register port and resets to 1000; it may be written only
// while no line is in flight.
module gcode_small_move_filter_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    char_valid,
  output logic                    char_stall,
  input  gsmf_pkg::char_word_t    char_word,
  output logic                    result_valid,
  input  logic                    result_stall,
  output gsmf_pkg::result_word_t  result_word,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic                   s1_valid;
  gsmf_pkg::char_word_t   s1_word;
  logic [29:0]            min_move;
  logic                   out_free;
  logic                   step;
  gsmf_pkg::result_word_t res;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == gsmf_pkg::REG_MIN_MOVE) ? {2'b00, min_move} : '0;
  assign out_free = !result_valid || !result_stall;
  assign step     = s1_valid && (!s1_word.last_in_line || out_free);
  assign char_stall = s1_valid && !step;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_move <= gsmf_pkg::MIN_MOVE_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == gsmf_pkg::REG_MIN_MOVE)) begin
      min_move <= pwdata[29:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!char_stall) begin
      s1_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!char_stall && char_valid) begin
      s1_word <= char_word;
    end
  end

  gsmf_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .word     (s1_word),
    .min_move (min_move),
    .result   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step && s1_word.last_in_line) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && s1_word.last_in_line) begin
      result_word <= res;
    end
  end

endmodule

### src/gsmf_parser.sv
// per-character line parser, number reader and move decision
module gsmf_parser (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  gsmf_pkg::char_word_t    word,
  input  logic [29:0]             min_move,
  output gsmf_pkg::result_word_t  result
);

  gsmf_pkg::line_state_t st;
  gsmf_pkg::line_state_t st_next;
  gsmf_pkg::line_state_t nm;
  gsmf_pkg::line_state_t w;
  logic signed [30:0] prev_x;
  logic signed [30:0] prev_y;
  logic signed [30:0] prev_x_next;
  logic signed [30:0] prev_y_next;

  logic [7:0]         ch;
  logic [7:0]         lc;
  logic               last;
  logic               is_digit;
  logic               is_point;
  logic               is_minus;
  logic               is_letter;
  logic               cont;
  logic [1:0]         fin_k;
  logic [1:0]         fin_j;
  logic [39:0]        fin_prod;
  logic [29:0]        fin_mag;
  logic signed [30:0] fin_val;
  logic               fin_gbig;
  logic               semi_dec;
  logic               dec_fire;
  logic signed [31:0] dx;
  logic signed [31:0] dy;
  logic [31:0]        adx;
  logic [31:0]        ady;
  logic               small_move;

  function automatic logic [29:0] sat_mul10_add(input logic [29:0] v, input logic [3:0] d);
    logic [33:0] r;
    r = 34'(v) * 34'd10 + 34'(d);
    return (r > 34'(gsmf_pkg::MAG_MAX)) ? gsmf_pkg::MAG_MAX : r[29:0];
  endfunction

  always_comb begin
    ch   = word.character;
    last = word.last_in_line;
    lc   = ch | gsmf_pkg::CASE_BIT;
    is_digit  = (ch >= gsmf_pkg::CH_ZERO) && (ch <= gsmf_pkg::CH_NINE);
    is_point  = (ch == gsmf_pkg::CH_POINT);
    is_minus  = (ch == gsmf_pkg::CH_MINUS);
    is_letter = ((ch >= gsmf_pkg::CH_UP_A) && (ch <= gsmf_pkg::CH_UP_Z)) ||
                ((ch >= gsmf_pkg::CH_LO_A) && (ch <= gsmf_pkg::CH_LO_Z));

    // number continues with this character
    nm = st;
    if (is_digit) begin
      if (!st.seen_point) begin
        nm.number_value = sat_mul10_add(st.number_value, ch[3:0]);
      end else if (st.fraction_digits < 2'(gsmf_pkg::FRAC_DIGITS)) begin
        nm.number_value    = sat_mul10_add(st.number_value, ch[3:0]);
        nm.fraction_digits = st.fraction_digits + 2'd1;
      end
    end else if (is_point) begin
      if (!st.seen_point) begin
        nm.seen_point      = 1'b1;
        nm.fraction_digits = 2'd0;
      end else begin
        nm.fraction_digits = 2'(gsmf_pkg::FRAC_DIGITS);
      end
    end else begin
      nm.number_negative = 1'b1;
    end
    nm.at_number_start = 1'b0;

    cont = !st.line_decided && st.in_number &&
           (is_digit || is_point || (is_minus && st.at_number_start));
    w = cont ? nm : st;

    // close the word: scale to fixed point and saturate
    fin_k    = w.seen_point ? w.fraction_digits : 2'd0;
    fin_j    = 2'(gsmf_pkg::FRAC_DIGITS) - fin_k;
    fin_prod = 40'(w.number_value) * 40'(gsmf_pkg::pow10(fin_j));
    fin_mag  = (fin_prod > 40'(gsmf_pkg::MAG_MAX)) ? gsmf_pkg::MAG_MAX : fin_prod[29:0];
    fin_val  = w.number_negative ? -$signed({1'b0, fin_mag}) : $signed({1'b0, fin_mag});
    fin_gbig = !w.number_negative && (fin_mag >= gsmf_pkg::G_LIMIT);

    if (!st.line_decided && w.in_number && (!cont || last)) begin
      w.in_number = 1'b0;
      unique case (w.pending_letter)
        gsmf_pkg::LETTER_X: w.line_x = fin_val;
        gsmf_pkg::LETTER_Y: w.line_y = fin_val;
        gsmf_pkg::LETTER_G: begin
          if (fin_gbig) begin
            w.line_decided   = 1'b1;
            w.decided_reason = gsmf_pkg::REASON_OTHER;
          end
        end
        gsmf_pkg::LETTER_NONE: ;
        default: ;
      endcase
    end

    semi_dec = 1'b0;
    if (!st.line_decided && !cont && !w.line_decided) begin
      priority if (ch == gsmf_pkg::CH_SEMI) begin
        semi_dec = 1'b1;
      end else if ((ch == gsmf_pkg::CH_LPAREN) || (ch == gsmf_pkg::CH_RPAREN)) begin
        w.in_comment = !w.in_comment;
      end else if ((ch <= gsmf_pkg::CH_SPACE) || ch[7] || w.in_comment) begin
        // skipped
      end else if (is_letter) begin
        if ((lc == gsmf_pkg::CH_LO_X) || (lc == gsmf_pkg::CH_LO_Y) ||
            (lc == gsmf_pkg::CH_LO_G)) begin
          w.pending_letter  = (lc == gsmf_pkg::CH_LO_X) ? gsmf_pkg::LETTER_X :
                              (lc == gsmf_pkg::CH_LO_Y) ? gsmf_pkg::LETTER_Y :
                                                          gsmf_pkg::LETTER_G;
          w.in_number       = 1'b1;
          w.number_value    = '0;
          w.fraction_digits = 2'd0;
          w.seen_point      = 1'b0;
          w.number_negative = 1'b0;
          w.at_number_start = 1'b1;
        end else begin
          w.line_decided   = 1'b1;
          w.decided_reason = gsmf_pkg::REASON_OTHER;
        end
      end
    end

    // letter on the last character reads as zero
    if (last && w.in_number && !w.line_decided) begin
      w.in_number = 1'b0;
      unique case (w.pending_letter)
        gsmf_pkg::LETTER_X: w.line_x = '0;
        gsmf_pkg::LETTER_Y: w.line_y = '0;
        gsmf_pkg::LETTER_G: ;
        gsmf_pkg::LETTER_NONE: ;
        default: ;
      endcase
    end

    dx  = 32'(w.line_x) - 32'(prev_x);
    dy  = 32'(w.line_y) - 32'(prev_y);
    adx = dx[31] ? -dx : dx;
    ady = dy[31] ? -dy : dy;
    small_move = (adx < {2'b00, min_move}) && (ady < {2'b00, min_move});

    dec_fire    = !w.line_decided && (semi_dec || last);
    prev_x_next = prev_x;
    prev_y_next = prev_y;
    if (dec_fire) begin
      w.line_decided = 1'b1;
      if (small_move) begin
        w.decided_reason = gsmf_pkg::REASON_SMALL;
      end else begin
        w.decided_reason = gsmf_pkg::REASON_MOVE;
        prev_x_next      = w.line_x;
        prev_y_next      = w.line_y;
      end
    end

    result.send_line       = (w.decided_reason != gsmf_pkg::REASON_SMALL);
    result.decision_reason = w.decided_reason;

    st_next = last ? '0 : w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= '0;
      prev_x <= '0;
      prev_y <= '0;
    end else if (step) begin
      st     <= st_next;
      prev_x <= prev_x_next;
      prev_y <= prev_y_next;
    end
  end

endmodule

### src/gsmf_checker.sv
// port checker for the small-move filter and its bind
`include "assert_macros.svh"

module gsmf_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   result_valid,
  input logic                   result_stall,
  input gsmf_pkg::result_word_t result_word
);

  logic reason_known;
  logic reason_sends;

  assign reason_known = (result_word.decision_reason <= gsmf_pkg::REASON_OTHER);
  assign reason_sends = (result_word.decision_reason != gsmf_pkg::REASON_SMALL);

  `GSMF_ASSERT_NXT(a_result_held, clk, rst, result_valid && result_stall, result_valid)
  `GSMF_ASSERT_NXT(a_result_stable, clk, rst, result_valid && result_stall, $stable(result_word))
  `GSMF_ASSERT_IMP(a_reason_code, clk, rst, result_valid, reason_known)
  `GSMF_ASSERT_IMP(a_send_matches, clk, rst, result_valid, result_word.send_line == reason_sends)

endmodule

bind gcode_small_move_filter_core gsmf_checker u_gsmf_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_word  (result_word)
);
